[design/grouped_constraint_inlier_counter_assert.svh]
// Assertion macros shared by the inlier counter checkers.
`ifndef GROUPED_CONSTRAINT_INLIER_COUNTER_ASSERT_SVH
`define GROUPED_CONSTRAINT_INLIER_COUNTER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define GCIC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define GCIC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define GCIC_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[design/gcic_pkg.sv]
// Shared constants and types for the grouped constraint inlier counter.
`default_nettype none
package gcic_pkg;

    localparam int DIMENSION   = 4;
    localparam int MAX_GROUP   = 16;
    localparam int COEF_FIELDS = 4;
    localparam int LANES       = (DIMENSION < COEF_FIELDS) ? DIMENSION : COEF_FIELDS;
    localparam int LANE_IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NPAIR       = (LANES + 1) / 2;

    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 4;
    localparam int FRAC_W  = 16;

    localparam int POS_W   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int GSIZE_W = 5;
    localparam int SIZE_W  = (GSIZE_W > $clog2(MAX_GROUP + 1)) ? GSIZE_W
                                                                : $clog2(MAX_GROUP + 1);
    localparam int COUNT_W = 24;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 8'd5;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic               done;
        logic               inlier;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage
`default_nettype wire

[design/gcic_lane.sv]
// One multiplier lane: coefficient times parameter, product registered.
`default_nettype none
module gcic_lane (
    input  wire                               aclk,
    input  wire                               en,
    input  wire  signed [gcic_pkg::DATA_W-1:0] coef,
    input  wire  signed [gcic_pkg::DATA_W-1:0] param,
    output gcic_pkg::prod_t                   prod
);
    import gcic_pkg::*;

    prod_t prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(coef) * PROD_W'(param);
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

[design/gcic_merge.sv]
// Merge stage: pairwise product sums registered, then total minus bound and sign test.
`default_nettype none
module gcic_merge (
    input  wire                  aclk,
    input  wire                  en,
    input  wire gcic_pkg::prod_t prod [gcic_pkg::LANES],
    input  wire gcic_pkg::sum_t  bound,
    output logic                 fail
);
    import gcic_pkg::*;

    sum_t pair_reg [NPAIR];
    sum_t bound_reg;
    sum_t total;

    for (genvar g = 0; g < NPAIR; g++) begin : g_pair
        if (2 * g + 1 < LANES) begin : g_two
            always_ff @(posedge aclk) begin
                if (en) begin
                    pair_reg[g] <= SUM_W'(prod[2*g]) + SUM_W'(prod[2*g+1]);
                end
            end
        end else begin : g_one
            always_ff @(posedge aclk) begin
                if (en) begin
                    pair_reg[g] <= SUM_W'(prod[2*g]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bound_reg <= bound;
        end
    end

    // positive residual beyond the limit fails the row
    always_comb begin
        total = -bound_reg;
        for (int i = 0; i < NPAIR; i++) begin
            total = total + pair_reg[i];
        end
        fail = !total[SUM_W-1] && (total != '0);
    end

endmodule
`default_nettype wire

[design/gcic_group.sv]
// Group tracker: position, verdict, saturating count and the result register.
`default_nettype none
module gcic_group (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              load,
    input  wire                              start,
    input  wire                              fail,
    input  wire  [gcic_pkg::GSIZE_W-1:0]     group_size,
    output gcic_pkg::result_t                result
);
    import gcic_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next, pos_in;
    logic               ok_reg, ok_next, ok_in, ok_row;
    logic [COUNT_W-1:0] tot_reg, tot_next, tot_in;
    logic [SIZE_W-1:0]  size_eff;
    logic               close;
    result_t            result_reg, result_next;

    always_comb begin
        pos_in = start ? '0 : pos_reg;
        ok_in  = start ? 1'b1 : ok_reg;
        tot_in = start ? '0 : tot_reg;
        ok_row = ok_in && !fail;

        priority if (group_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (SIZE_W'(group_size) > SIZE_W'(MAX_GROUP)) begin
            size_eff = SIZE_W'(MAX_GROUP);
        end else begin
            size_eff = SIZE_W'(group_size);
        end

        close = (SIZE_W'(pos_in) + SIZE_W'(1)) >= size_eff;

        if (close) begin
            pos_next = '0;
            ok_next  = 1'b1;
            tot_next = (ok_row && tot_in != COUNT_MAX) ? tot_in + 1'b1 : tot_in;
        end else begin
            pos_next = pos_in + 1'b1;
            ok_next  = ok_row;
            tot_next = tot_in;
        end

        result_next.done   = close;
        result_next.inlier = close && ok_row;
        result_next.count  = tot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ok_reg  <= 1'b1;
            tot_reg <= '0;
        end else if (load) begin
            pos_reg <= pos_next;
            ok_reg  <= ok_next;
            tot_reg <= tot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

[design/grouped_constraint_inlier_counter.sv]
// Pipeline: an accepted row passes through the lane, merge and output registers in turn.
// Throughput: one row per cycle unless the result channel stalls; four parallel 32x32
//   multiplier lanes and a two-level adder tree sustain it, and the per-row group update
//   closes in the output stage.
// Reset: synchronous, active-low aresetn clears all valid flags, group position, verdict and
//   count, and restores parameters and limit to zero and group size to one.
`default_nettype none
module grouped_constraint_inlier_counter (
    input  wire         aclk,
    input  wire         aresetn,
    // row input channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [159:0] s_tdata,   // coef_0, coef_1, coef_2, coef_3, target (32 bits each)
    input  wire         s_tuser,   // start_set
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // inlier_count
    output logic        m_tuser,   // group_inlier
    output logic        m_tlast,   // group_done
    // configuration write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_index,
    input  wire [31:0]  cfg_data
);
    import gcic_pkg::*;

    // configuration registers
    logic signed [DATA_W-1:0] param_reg [COEF_FIELDS];
    logic signed [DATA_W-1:0] limit_reg;
    logic [GSIZE_W-1:0]       gsize_reg;

    // pipeline control
    logic v1_reg, v1_next, v2_reg, v2_next, mv_reg, mv_next;
    logic start1_reg, start2_reg;
    logic rdy_out, stage2_free, in_ld, ld2, out_ld;

    sum_t    bound1_reg;
    prod_t   prod [LANES];
    logic    fail;
    result_t result;

    // Configuration: always ready, taken whenever the transfer is offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COEF_FIELDS; i++) begin
                param_reg[i] <= '0;
            end
            limit_reg <= '0;
            gsize_reg <= GSIZE_W'(1);
        end else if (cfg_valid) begin
            priority if (cfg_index < REG_PARAM_BASE + CFG_IDX_W'(COEF_FIELDS)) begin
                param_reg[cfg_index[LANE_IDX_W-1:0]] <= cfg_data;
            end else if (cfg_index == REG_LIMIT) begin
                limit_reg <= cfg_data;
            end else if (cfg_index == REG_GROUP_SIZE) begin
                gsize_reg <= cfg_data[GSIZE_W-1:0];
            end else begin
                // drop writes to unmapped indexes
                limit_reg <= limit_reg;
            end
        end
    end

    // Handshake: each stage advances when the one ahead is empty or draining,
    // so rows behind a waiting result still move up into any empty stages.
    always_comb begin
        rdy_out     = !mv_reg || m_tready;
        stage2_free = !v2_reg || rdy_out;
        s_tready    = !v1_reg || stage2_free;
        in_ld       = s_tvalid && s_tready;
        ld2         = v1_reg && stage2_free;
        out_ld      = v2_reg && rdy_out;

        v1_next = in_ld ? 1'b1 : (ld2 ? 1'b0 : v1_reg);
        v2_next = ld2 ? 1'b1 : (out_ld ? 1'b0 : v2_reg);
        mv_next = out_ld ? 1'b1 : (m_tready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            mv_reg <= mv_next;
        end
    end

    // Stage one: hold the start flag and the scaled bound (target + limit) at Q32.32.
    always_ff @(posedge aclk) begin
        if (in_ld) begin
            start1_reg <= s_tuser;
            bound1_reg <= (SUM_W'($signed(s_tdata[COEF_FIELDS*DATA_W +: DATA_W]))
                           + SUM_W'(limit_reg)) <<< FRAC_W;
        end
        if (ld2) begin
            start2_reg <= start1_reg;
        end
    end

    // Stage one: one multiplier per coefficient.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        gcic_lane u_lane (
            .aclk  (aclk),
            .en    (in_ld),
            .coef  ($signed(s_tdata[g*DATA_W +: DATA_W])),
            .param (param_reg[g]),
            .prod  (prod[g])
        );
    end

    // Stage two: combine lane products and test against the bound.
    gcic_merge u_merge (
        .aclk  (aclk),
        .en    (ld2),
        .prod  (prod),
        .bound (bound1_reg),
        .fail  (fail)
    );

    // Output stage: advance the group state and register the result.
    gcic_group u_group (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (out_ld),
        .start      (start2_reg),
        .fail       (fail),
        .group_size (gsize_reg),
        .result     (result)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = result.count;
    assign m_tuser  = result.inlier;
    assign m_tlast  = result.done;

endmodule
`default_nettype wire

[design/gcic_checker.sv]
// Port-level checker for the inlier counter, bound to the top level.
`default_nettype none
`include "grouped_constraint_inlier_counter_assert.svh"
module gcic_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire        m_tuser,
    input wire        m_tlast
);

    logic        m_inlier;
    logic        m_stall;
    logic [25:0] m_word;

    assign m_inlier = m_tvalid && m_tuser;
    assign m_stall  = m_tvalid && !m_tready;
    assign m_word   = {m_tlast, m_tuser, m_tdata};

    // an inlier verdict only comes with a closed group
    `GCIC_ASSERT_IMP(a_inlier_needs_done, aclk, aresetn, m_inlier, m_tlast, "inlier, no close")

    // a stalled result holds
    `GCIC_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_stall, m_tvalid && $stable(m_word), "stall")

    // no result straight out of reset
    `GCIC_ASSERT_RST(a_reset_idle, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind grouped_constraint_inlier_counter gcic_checker u_gcic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

[tb/sv/gcic_result_checker.sv]
// Result checker for the grouped constraint inlier counter: watches all channels and scores results.
`timescale 1ns / 1ps
module gcic_result_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire [5*gcic_pkg::DATA_W-1:0]    s_tdata,    // coef_0, coef_1, coef_2, coef_3, target
    input  wire                             s_tuser,    // start_set
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [gcic_pkg::COUNT_W-1:0]     m_tdata,    // inlier_count
    input  wire                             m_tuser,    // group_inlier
    input  wire                             m_tlast,    // group_done
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire [gcic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [gcic_pkg::DATA_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import gcic_pkg::*;

    logic signed [DATA_W-1:0] weight [COEF_FIELDS];
    logic signed [DATA_W-1:0] limit_q;
    logic [GSIZE_W-1:0]       size_reg;

    logic [POS_W-1:0]   row_pos;
    logic               open_ok;
    logic [COUNT_W-1:0] total;

    result_t awaited_results [$];
    int      fail_total = 0;
    int      queued     = 0;

    assign mismatches  = fail_total;
    assign outstanding = queued;

    // Exact Q32.32 comparison: dot product against (target + limit) scaled up by 2^16.
    function automatic logic row_exceeds_limit(input logic [5*DATA_W-1:0] row);
        logic signed [71:0]       dot;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] t;
        int                       i;
        dot = '0;
        for (i = 0; i < LANES; i++) begin
            c   = row[i*DATA_W +: DATA_W];
            dot = dot + c * weight[i];
        end
        t = row[4*DATA_W +: DATA_W];
        return dot > (t + limit_q) * 72'sd65536;
    endfunction

    // Advance the group state by one row and return the result it produces.
    function automatic result_t advance_group(input logic start, input logic [5*DATA_W-1:0] row);
        result_t r;
        int      eff;
        if (start) begin
            row_pos = '0;
            open_ok = 1'b1;
            total   = '0;
        end
        if (row_exceeds_limit(row))
            open_ok = 1'b0;
        eff = (size_reg == 0) ? 1 : ((size_reg > MAX_GROUP) ? MAX_GROUP : int'(size_reg));
        if (int'(row_pos) + 1 >= eff) begin
            r.done   = 1'b1;
            r.inlier = open_ok;
            if (open_ok && total != COUNT_MAX)
                total = total + 1'b1;
            row_pos = '0;
            open_ok = 1'b1;
        end else begin
            r.done   = 1'b0;
            r.inlier = 1'b0;
            row_pos  = row_pos + 1'b1;
        end
        r.count = total;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        int      slot;
        if (!aresetn) begin
            for (slot = 0; slot < COEF_FIELDS; slot++)
                weight[slot] = '0;
            limit_q  = '0;
            size_reg = GSIZE_W'(1);
            row_pos  = '0;
            open_ok  = 1'b1;
            total    = '0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with none awaited: done %0b inlier %0b count %0d",
                             $time, m_tlast, m_tuser, m_tdata);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tlast !== want.done) begin
                        $display("%0t ns: group_done expected %0b actual %0b",
                                 $time, want.done, m_tlast);
                        fail_total++;
                    end
                    if (m_tuser !== want.inlier) begin
                        $display("%0t ns: group_inlier expected %0b actual %0b",
                                 $time, want.inlier, m_tuser);
                        fail_total++;
                    end
                    if (m_tdata !== want.count) begin
                        $display("%0t ns: inlier_count expected %0d actual %0d",
                                 $time, want.count, m_tdata);
                        fail_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(), advance_group(s_tuser, s_tdata));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_LIMIT) begin
                    limit_q = cfg_data;
                end else if (cfg_index == REG_GROUP_SIZE) begin
                    size_reg = cfg_data[GSIZE_W-1:0];
                end else begin
                    slot = int'(cfg_index) - int'(REG_PARAM_BASE);
                    if (slot >= 0 && slot < COEF_FIELDS)
                        weight[slot] = cfg_data;
                end
            end
        end
        queued = awaited_results.size();
    end

endmodule

[tb/sv/grouped_constraint_inlier_counter_tb.sv]
// Top-level testbench for the grouped constraint inlier counter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module grouped_constraint_inlier_counter_tb;
    import gcic_pkg::*;

    localparam int ROW_W       = 5 * DATA_W;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 11;
    // Leave a generous margin after the last result.
    localparam int DRAIN_CYCLES = 12;
    // No transfer for this many cycles means the block has hung. The longest quiet
    // stretch in a correct run is reset plus a drain pause, far below this.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int CHUNKS     = 16;
    localparam int CHUNK_ROWS = 100;

    localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ZERO  = 32'h0000_0000;
    localparam logic [DATA_W-1:0] LSB_NEG = 32'hFFFF_FFFF;

    // Indexes that decode to no register; the block must ignore them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [ROW_W-1:0]     s_tdata   = '0;   // coef_0, coef_1, coef_2, coef_3, target
    logic                 s_tuser   = 1'b0; // start_set
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    wire                  s_tready;
    wire                  m_tvalid;
    wire [COUNT_W-1:0]    m_tdata;          // inlier_count
    wire                  m_tuser;          // group_inlier
    wire                  m_tlast;          // group_done
    wire                  cfg_ready;

    int mismatches;
    int outstanding;

    int send_idle_pct  = 30;
    int recv_stall_pct = 58;
    int quiet_cycles   = 0;

    // Copy of what has been written, used only to aim rows at the threshold.
    logic signed [DATA_W-1:0] shadow_param [COEF_FIELDS] = '{default: '0};
    logic signed [DATA_W-1:0] shadow_limit = '0;

    grouped_constraint_inlier_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gcic_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    // Receiver back-pressure: redraw ready every falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: count cycles without any transfer on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [ROW_W-1:0] pack_row(input logic [DATA_W-1:0] c0,
                                                  input logic [DATA_W-1:0] c1,
                                                  input logic [DATA_W-1:0] c2,
                                                  input logic [DATA_W-1:0] c3,
                                                  input logic [DATA_W-1:0] t);
        return {t, c3, c2, c1, c0};
    endfunction

    // Draw a row: a few fully random, most small and comfortably inside the limit,
    // the rest aimed within a couple of LSBs of the threshold.
    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] c;
        logic signed [71:0]       dot;
        logic signed [71:0]       aim;
        int                       kind;
        int                       i;
        kind = $urandom_range(0, 9);
        dot  = '0;
        for (i = 0; i < COEF_FIELDS; i++) begin
            if (kind < 2)
                c = $urandom;
            else
                c = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            row[i*DATA_W +: DATA_W] = c;
            dot = dot + c * shadow_param[i];
        end
        if (kind < 2) begin
            row[4*DATA_W +: DATA_W] = $urandom;
        end else if (kind < 7) begin
            row[4*DATA_W +: DATA_W] = 32'h4000_0000 | $urandom_range(0, 32'h3FFF_FFFF);
        end else begin
            aim = (dot >>> FRAC_W) - shadow_limit + ($signed($urandom_range(0, 4)) - 2);
            row[4*DATA_W +: DATA_W] = aim[DATA_W-1:0];
        end
        return row;
    endfunction

    // Present one row and hold it until the transfer; leave valid high on return
    // so that back-to-back rows never drop valid within one time step.
    task automatic send_row(input logic start, input logic [ROW_W-1:0] row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Hold the sender, wait for every awaited result, then let the pipe empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One register transfer; valid stays high so the caller can chain writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        int slot;
        slot = int'(idx) - int'(REG_PARAM_BASE);
        if (idx == REG_LIMIT)
            shadow_limit = val;
        else if (slot >= 0 && slot < COEF_FIELDS && idx != REG_GROUP_SIZE)
            shadow_param[slot] = val;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] p0, input logic [DATA_W-1:0] p1,
                                  input logic [DATA_W-1:0] p2, input logic [DATA_W-1:0] p3,
                                  input logic [DATA_W-1:0] lim, input logic [DATA_W-1:0] gsz);
        write_reg(REG_PARAM_BASE,               p0);
        write_reg(REG_PARAM_BASE + 8'd1,        p1);
        write_reg(REG_PARAM_BASE + 8'd2,        p2);
        write_reg(REG_PARAM_BASE + 8'd3,        p3);
        write_reg(REG_LIMIT,                    lim);
        write_reg(REG_GROUP_SIZE,               gsz);
    endtask

    function automatic logic [DATA_W-1:0] random_q16();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
            1:       return $urandom;
            default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        endcase
    endfunction

    // New parameters, limit and group size; mostly small groups so inliers occur.
    task automatic load_random_settings();
        logic [DATA_W-1:0] gsz;
        if ($urandom_range(0, 3) == 0)
            gsz = $urandom_range(0, 31);
        else
            gsz = $urandom_range(1, 4);
        gsz = gsz | ($urandom & 32'hFFFF_FFE0);
        apply_settings(random_q16(), random_q16(), random_q16(), random_q16(),
                       random_q16(), gsz);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_rows();
        // Unit parameters, zero limit, one row per group.
        apply_settings(Q_ONE, Q_ONE, Q_ONE, Q_ONE, ZERO, 32'd1);
        write_reg(REG_SPARE, $urandom);
        write_reg(REG_TOP, $urandom);
        cfg_valid <= 1'b0;
        send_row(1'b1, pack_row(S_MAX, S_MAX, S_MAX, S_MAX, S_MIN));
        send_row(1'b0, pack_row(S_MIN, S_MIN, S_MIN, S_MIN, S_MAX));
        // Residual exactly at the limit passes; one LSB more fails.
        send_row(1'b0, pack_row(Q_ONE, ZERO, ZERO, ZERO, Q_ONE));
        send_row(1'b0, pack_row(Q_ONE + 32'd1, ZERO, ZERO, ZERO, Q_ONE));
        settle();

        // Extreme parameters and limit; group size zero behaves as one.
        apply_settings(S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, 32'd0);
        cfg_valid <= 1'b0;
        send_row(1'b0, pack_row(S_MIN, S_MIN, S_MAX, S_MAX, S_MAX));
        send_row(1'b0, pack_row(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
        send_row(1'b0, pack_row(ZERO, ZERO, ZERO, ZERO, ZERO));
        settle();

        // Oversized group clamps to the maximum; a start row drops the open group.
        write_reg(REG_LIMIT, S_MIN);
        write_reg(REG_GROUP_SIZE, 32'd31);
        cfg_valid <= 1'b0;
        repeat (4) send_row(1'b0, pack_row(ZERO, ZERO, ZERO, ZERO, ZERO));
        send_row(1'b1, pack_row(ZERO, ZERO, ZERO, ZERO, S_MAX));
        settle();

        // Grow the open group under size five, then shrink to two mid-group.
        write_reg(REG_LIMIT, ZERO);
        write_reg(REG_GROUP_SIZE, 32'd5);
        cfg_valid <= 1'b0;
        repeat (2) send_row(1'b0, pack_row(ZERO, ZERO, ZERO, ZERO, Q_ONE));
        settle();
        write_reg(REG_GROUP_SIZE, 32'd2);
        cfg_valid <= 1'b0;
        repeat (3) send_row(1'b0, pack_row(ZERO, ZERO, ZERO, ZERO, Q_ONE));
        settle();

        // Group of three with one failing row in the middle.
        write_reg(REG_GROUP_SIZE, 32'd3);
        cfg_valid <= 1'b0;
        send_row(1'b0, pack_row(ZERO, ZERO, ZERO, ZERO, Q_ONE));
        send_row(1'b0, pack_row(ZERO, ZERO, ZERO, ZERO, LSB_NEG));
        send_row(1'b0, pack_row(ZERO, ZERO, ZERO, ZERO, Q_ONE));
        settle();
    endtask

    initial begin : stimulus
        int chunk;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_rows();

        // Random chunks: swap idling between sides after the first third,
        // then run flat out. Each reconfiguration waits for the pipe to drain.
        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            if (chunk == CHUNKS / 3) begin
                send_idle_pct  = 58;
                recv_stall_pct = 30;
            end else if (chunk == (2 * CHUNKS) / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            load_random_settings();
            repeat (CHUNK_ROWS)
                send_row($urandom_range(0, 31) == 0, random_row());
            settle();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
